### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

### rtl/core/wmac_pkg.sv
// ----------------------------------------------------------------------------
// wmac_pkg
// shared constants, state type and control structs of the averaging block
// ----------------------------------------------------------------------------
package wmac_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 12;
    localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = $clog2(WINDOW_DEPTH * 4095 + 1);
    localparam int DIV_CNT_W    = $clog2(SUM_W);

    localparam logic [SAMPLE_W-1:0] AVG_MIN = SAMPLE_W'(1);
    localparam logic [SAMPLE_W-1:0] AVG_MAX = SAMPLE_W'(4095);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/core/warmup_moving_average_clamp_top.sv
// ----------------------------------------------------------------------------
// warmup_moving_average_clamp_top
// Moving average of a 12-bit light sensor over the last 16 words. Each input
// word stores its sample in the window and yields one word holding the mean
// of the samples stored so far (up to 16), truncated and clamped to
// 1..4095, so the average is valid from the first sample on. Each item is
// handled in order: update of the window and running sum, the bit-serial
// divider (one quotient bit per cycle over the 16-bit sum), then the load
// of the output register once it is free downstream. A new word is taken
// the cycle after the result is loaded, while that result waits downstream,
// so no new word is taken before the last result is loaded.
// ----------------------------------------------------------------------------
module warmup_moving_average_clamp_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wmac_pkg::TDATA_W-1:0] s_tdata,   // [11:0] sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wmac_pkg::TDATA_W-1:0] m_tdata    // [11:0] average
);

    wmac_pkg::ctrl_cmd_t           cmd;
    wmac_pkg::ctrl_status_t        status;
    logic [wmac_pkg::SAMPLE_W-1:0] average;

    wmac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wmac_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sample   (s_tdata[wmac_pkg::SAMPLE_W-1:0]),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .average  (average)
    );

    assign m_tdata = wmac_pkg::TDATA_W'(average);

endmodule

### rtl/core/wmac_ctrl.sv
// ----------------------------------------------------------------------------
// wmac_ctrl
// sequencer: take a word, update the window, run the divider, hand off result
// ----------------------------------------------------------------------------
module wmac_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  wmac_pkg::ctrl_status_t status,
    output wmac_pkg::ctrl_cmd_t    cmd
);

    wmac_pkg::state_t state_reg;
    wmac_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmac_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wmac_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = wmac_pkg::S_UPDATE;
                end
            end
            wmac_pkg::S_UPDATE: begin
                state_next = wmac_pkg::S_DIVIDE;
            end
            wmac_pkg::S_DIVIDE: begin
                if (status.div_last) begin
                    state_next = wmac_pkg::S_DONE;
                end
            end
            wmac_pkg::S_DONE: begin
                if (status.out_free) begin
                    state_next = wmac_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wmac_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            wmac_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            wmac_pkg::S_UPDATE: begin
                cmd.update = 1'b1;
            end
            wmac_pkg::S_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            wmac_pkg::S_DONE: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/wmac_dpath.sv
// ----------------------------------------------------------------------------
// wmac_dpath
// sample window, running sum, bit-serial divider, clamp and output register
// ----------------------------------------------------------------------------
module wmac_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [wmac_pkg::SAMPLE_W-1:0]        sample,
    input  wmac_pkg::ctrl_cmd_t                  cmd,
    output wmac_pkg::ctrl_status_t               status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [wmac_pkg::SAMPLE_W-1:0]        average
);

    logic [wmac_pkg::SAMPLE_W-1:0]  ring_reg [wmac_pkg::WINDOW_DEPTH];
    logic [wmac_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [wmac_pkg::PTR_W-1:0]     wp_reg;
    logic [wmac_pkg::PTR_W-1:0]     wp_next;
    logic [wmac_pkg::CNT_W-1:0]     fill_reg;
    logic [wmac_pkg::CNT_W-1:0]     fill_next;
    logic [wmac_pkg::SUM_W-1:0]     sum_reg;
    logic [wmac_pkg::SUM_W-1:0]     sum_next;

    logic [wmac_pkg::CNT_W-1:0]     rem_reg;
    logic [wmac_pkg::CNT_W-1:0]     rem_next;
    logic [wmac_pkg::CNT_W-1:0]     dvs_reg;
    logic [wmac_pkg::SUM_W-1:0]     quot_reg;
    logic [wmac_pkg::SUM_W-1:0]     quot_next;
    logic [wmac_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [wmac_pkg::CNT_W:0]       shifted;
    logic [wmac_pkg::CNT_W:0]       diff;
    logic                           qbit;

    logic [wmac_pkg::SAMPLE_W-1:0]  clamped;
    logic                           out_valid_reg;
    logic [wmac_pkg::SAMPLE_W-1:0]  out_data_reg;

    // window update
    always_comb begin
        sum_next = sum_reg - wmac_pkg::SUM_W'(ring_reg[wp_reg])
                 + wmac_pkg::SUM_W'(sample_reg);
        if (wp_reg == wmac_pkg::PTR_W'(wmac_pkg::WINDOW_DEPTH - 1)) begin
            wp_next = '0;
        end else begin
            wp_next = wp_reg + wmac_pkg::PTR_W'(1);
        end
        if (fill_reg < wmac_pkg::CNT_W'(wmac_pkg::WINDOW_DEPTH)) begin
            fill_next = fill_reg + wmac_pkg::CNT_W'(1);
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wmac_pkg::WINDOW_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end else if (cmd.update) begin
            ring_reg[wp_reg] <= sample_reg;
            wp_reg           <= wp_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= sample;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        shifted = {rem_reg, quot_reg[wmac_pkg::SUM_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        qbit    = (shifted >= {1'b0, dvs_reg});
        if (qbit) begin
            rem_next = diff[wmac_pkg::CNT_W-1:0];
        end else begin
            rem_next = shifted[wmac_pkg::CNT_W-1:0];
        end
        quot_next = {quot_reg[wmac_pkg::SUM_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            rem_reg  <= '0;
            quot_reg <= sum_next;
            dvs_reg  <= fill_next;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.update) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + wmac_pkg::DIV_CNT_W'(1);
        end
    end

    // clamp to 1..4095
    always_comb begin
        if (|quot_reg[wmac_pkg::SUM_W-1:wmac_pkg::SAMPLE_W]) begin
            clamped = wmac_pkg::AVG_MAX;
        end else if (quot_reg[wmac_pkg::SAMPLE_W-1:0] < wmac_pkg::AVG_MIN) begin
            clamped = wmac_pkg::AVG_MIN;
        end else begin
            clamped = quot_reg[wmac_pkg::SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= clamped;
        end
    end

    assign status.div_last = (div_cnt_reg == wmac_pkg::DIV_CNT_W'(wmac_pkg::SUM_W - 1));
    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign average         = out_data_reg;

endmodule

### rtl/core/wmac_checker.sv
// ----------------------------------------------------------------------------
// wmac_checker
// port-level checks of the averaging block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmac_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [wmac_pkg::TDATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [wmac_pkg::TDATA_W-1:0] m_tdata
);

    logic s_fire;
    logic s_data_ok;

    assign s_fire    = s_tvalid && s_tready;
    assign s_data_ok = (s_tdata == s_tdata);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // result lies in 1..4095 with zero padding
    `ASSERT_SAME(a_out_range, m_tvalid, (m_tdata != '0) && (m_tdata <= wmac_pkg::TDATA_W'(4095)))
    // one word in flight at a time
    `ASSERT_NEXT(a_no_back_to_back, s_fire && s_data_ok, !s_tready)
    // no result appears right after a word is taken
    `ASSERT_NEXT(a_no_instant_out, s_fire, !$rose(m_tvalid))

endmodule

bind warmup_moving_average_clamp_top wmac_checker u_wmac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb_warmup_moving_average_clamp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_warmup_moving_average_clamp_top
// Drives light sensor samples into the averaging block with random gaps and
// output stalls. A local window model works out each expected mean. Results
// are checked in order. The first part is directed: it covers zero and full
// scale samples, window wraparound and padding bits above the sample. After
// that come random runs of low, high, constant and noisy samples.
// ----------------------------------------------------------------------------
module tb_warmup_moving_average_clamp_top;
    import wmac_pkg::*;

    localparam int CALM_TAIL = 150;
    localparam int RAND_WORDS = 1725;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    warmup_moving_average_clamp_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    logic [TDATA_W-1:0]  pending[$];
    logic [SAMPLE_W-1:0] mean_queue[$];

    logic [SAMPLE_W-1:0] win_ring[WINDOW_DEPTH];
    logic [PTR_W-1:0]    win_ptr = '0;
    logic [CNT_W-1:0]    win_fill = '0;
    logic [SUM_W-1:0]    win_sum = '0;

    int words_sent = 0;
    int means_checked = 0;
    int floor_hits = 0;
    int err_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int send_gap = 0;
    int stall_left = 0;

    initial begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ring[i] = '0;
        end
    end

    function automatic logic [SAMPLE_W-1:0] window_mean(input logic [TDATA_W-1:0] word);
        logic [SAMPLE_W-1:0] fresh;
        logic [SUM_W-1:0]    quot;
        fresh = word[SAMPLE_W-1:0];
        win_sum = win_sum - SUM_W'(win_ring[win_ptr]) + SUM_W'(fresh);
        win_ring[win_ptr] = fresh;
        win_ptr = (int'(win_ptr) == WINDOW_DEPTH - 1) ? '0 : win_ptr + 1'b1;
        if (int'(win_fill) < WINDOW_DEPTH) begin
            win_fill = win_fill + 1'b1;
        end
        quot = win_sum / SUM_W'(win_fill);
        if (quot < SUM_W'(AVG_MIN)) begin
            quot = SUM_W'(AVG_MIN);
        end
        if (quot > SUM_W'(AVG_MAX)) begin
            quot = SUM_W'(AVG_MAX);
        end
        return quot[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 25;
            default: return 60;
        endcase
    endfunction

    // input side
    always @(posedge aclk) begin : drive
        logic               nxt_valid;
        logic [TDATA_W-1:0] nxt_data;
        logic [SAMPLE_W-1:0] mean;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                mean = window_mean(s_tdata);
                mean_queue.push_back(mean);
                if (mean == AVG_MIN) begin
                    floor_hits++;
                end
                words_sent++;
                if (words_sent % 128 == 0) begin
                    gap_pct = pick_pct();
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending.size() > 0) begin
                    if (pending.size() > CALM_TAIL && $urandom_range(99) < gap_pct) begin
                        send_gap = $urandom_range(15);
                    end else begin
                        nxt_data  = pending.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // output side
    always @(posedge aclk) begin : watch
        logic [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (mean_queue.size() == 0) begin
                    if (err_count < 10) begin
                        $display("%0t: unexpected average %0d", $time, m_tdata[SAMPLE_W-1:0]);
                    end
                    err_count++;
                end else begin
                    want = mean_queue.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want) begin
                        if (err_count < 10) begin
                            $display("%0t: average mismatch, expected %0d, got %0d",
                                     $time, want, m_tdata[SAMPLE_W-1:0]);
                        end
                        err_count++;
                    end
                    means_checked++;
                    if (means_checked % 100 == 0) begin
                        stall_pct = pick_pct();
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (pending.size() > CALM_TAIL && $urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int kind;
        int run_len;
        int level;
        logic [SAMPLE_W-1:0] smp;
        logic [3:0] pad;

        // zero samples floor at one, padding bits must be ignored
        pending.push_back(16'h0000);
        pending.push_back(16'hF000);
        pending.push_back(16'hFFFF);
        // full scale until the window wraps
        for (int i = 0; i < 17; i++) begin
            pending.push_back(TDATA_W'(AVG_MAX));
        end
        pending.push_back(16'h0001);
        pending.push_back(16'h8001);
        pending.push_back(16'h5A5A);
        pending.push_back(16'hA5A5);

        while (pending.size() < 25 + RAND_WORDS) begin
            kind    = $urandom_range(4);
            run_len = $urandom_range(40, 1);
            level   = $urandom_range(4095);
            for (int i = 0; i < run_len; i++) begin
                case (kind)
                    0: smp = SAMPLE_W'($urandom_range(15));
                    1: smp = SAMPLE_W'($urandom_range(4095, 4080));
                    2: smp = SAMPLE_W'(level);
                    3: smp = '0;
                    default: smp = SAMPLE_W'($urandom_range(4095));
                endcase
                pad = ($urandom_range(7) == 0) ? 4'($urandom) : 4'h0;
                pending.push_back({pad, smp});
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_tvalid || mean_queue.size() > 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("sent %0d samples, checked %0d averages (%0d at the floor of one)",
                 words_sent, means_checked, floor_hits);
        $display("mismatches or stray results: %0d", err_count);
        if (err_count == 0 && mean_queue.size() == 0) begin
            $display("tb_warmup_moving_average_clamp_top: clean");
        end else begin
            $display("tb_warmup_moving_average_clamp_top: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d averages outstanding", mean_queue.size());
        $display("tb_warmup_moving_average_clamp_top: errors");
        $finish;
    end

endmodule
